// ===== rtl/hll_pkg.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update package
// Operation codes, field widths and helper functions for the sketch block.
// ----------------------------------------------------------------------------
package hll_pkg;

    localparam int MAX_REGISTERS_DEF = 65536;
    localparam int OP_W              = 2;
    localparam int CFG_W             = 5;
    localparam int HIDX_W            = 32;
    localparam int HRANK_W           = 64;
    localparam int RIDX_W            = 16;
    localparam int VAL_W             = 7;
    localparam int CNT_W             = 17;
    localparam int BITS_MIN          = 4;
    localparam int BITS_MAX          = 16;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET = CFG_W'(BITS_MIN);
    localparam logic [VAL_W-1:0] RANK_MAX         = VAL_W'(65);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_MERGE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    function automatic logic [CFG_W-1:0] used_bits(input logic [CFG_W-1:0] bits);
        logic [CFG_W-1:0] b;
        b = bits;
        if (bits < CFG_W'(BITS_MIN)) b = CFG_W'(BITS_MIN);
        if (bits > CFG_W'(BITS_MAX)) b = CFG_W'(BITS_MAX);
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] count_of(input logic [CFG_W-1:0] bits,
                                                  input logic [CNT_W-1:0] max_regs);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1) << used_bits(bits);
        if (n > max_regs) n = max_regs;
        return n;
    endfunction

    function automatic logic [VAL_W-1:0] rank_of(input logic [HRANK_W-1:0] w);
        logic [2:0] byte_sel;
        logic [2:0] bit_sel;
        logic [7:0] sel_byte;
        logic       found_byte;
        logic       found_bit;
        byte_sel   = '0;
        bit_sel    = '0;
        found_byte = 1'b0;
        found_bit  = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found_byte && (w[8*i +: 8] != 8'd0)) begin
                found_byte = 1'b1;
                byte_sel   = 3'(i);
            end
        end
        sel_byte = w[{byte_sel, 3'b000} +: 8];
        for (int j = 0; j < 8; j++) begin
            if (!found_bit && sel_byte[j]) begin
                found_bit = 1'b1;
                bit_sel   = 3'(j);
            end
        end
        if (!found_byte) return RANK_MAX;
        return VAL_W'({byte_sel, bit_sel}) + VAL_W'(1);
    endfunction

endpackage

// ===== rtl/hll_ram.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog generic RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hll_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/hyperloglog_register_update_top.sv =====
// ----------------------------------------------------------------------------
// HyperLogLog register update
// Rank register bank of a HyperLogLog sketch with add, merge, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an operation beat is taken at a clock edge where start
//   is high and busy is low. Add hashes a register index from the top
//   index_bits bits of hash_index_word and a rank from the trailing zeros of
//   hash_rank_word; merge and read use register_index.
//   Result channel: done pulses for one cycle with register_value and
//   zero_count once the command beat has passed the s1 stage and the done register. The receiver cannot stall.
//   Throughput: one add, merge or read per cycle while busy is low. The register bank
//   sits in one RAM; a read is issued on the command beat and the write-back happens
//   in the cycle after, with a one-entry forward covering back-to-back updates
//   of the same register.
//   Clear: the result comes out as usual; busy stays high while the clear beat
//   is in s1 and then through the clearing pass, which zeroes one RAM entry a
//   cycle over every used register.
//   Configuration: a beat on cfg_valid/cfg_ready sets index_bits and starts
//   the same clearing pass over the new register count; a command beat in
//   the same cycle wins and cfg_ready drops.
//   Reset: index_bits returns to 4 and a clearing pass over the resulting
//   register count runs with busy high.
// ----------------------------------------------------------------------------
module hyperloglog_register_update_top
    import hll_pkg::*;
#(
    parameter int MAX_REGISTERS = MAX_REGISTERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    operation,
    input  logic [HIDX_W-1:0]  hash_index_word,
    input  logic [HRANK_W-1:0] hash_rank_word,
    input  logic [RIDX_W-1:0]  register_index,
    input  logic [VAL_W-1:0]   merge_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               done,
    output logic [VAL_W-1:0]   register_value,
    output logic [CNT_W-1:0]   zero_count
);

    localparam int ADDR_W = $clog2(MAX_REGISTERS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGISTERS);

    logic              accept;
    logic              cfg_beat;
    logic [CNT_W-1:0]  reg_count;
    op_t               s0_op;
    logic [RIDX_W-1:0] s0_idx;
    logic [VAL_W-1:0]  s0_val;
    logic [HIDX_W-1:0] hash_shifted;
    logic [CFG_W-1:0]  bits_used;

    logic [CFG_W-1:0]  index_bits_reg;
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    logic              s1_hit_reg;
    logic              sweep_reg,      sweep_next;
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [CNT_W-1:0]  zc_reg,         zc_next;
    logic              fwd_valid_reg,  fwd_valid_next;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [VAL_W-1:0]  fwd_data_reg;
    logic              done_reg;
    logic [VAL_W-1:0]  value_reg,      value_next;

    logic [VAL_W-1:0]  rd_data;
    logic [VAL_W-1:0]  old_val;
    logic [VAL_W-1:0]  new_val;
    logic              grow;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              sweep_last;

    assign reg_count = count_of(index_bits_reg, MAX_CNT);
    assign busy      = sweep_reg | (s1_valid_reg & (s1_op_reg == OP_CLEAR));
    assign accept    = start & ~busy;
    assign cfg_ready = ~s1_valid_reg & ~accept;
    assign cfg_beat  = cfg_valid & cfg_ready;

    assign s0_op        = op_t'(operation);
    assign bits_used    = used_bits(index_bits_reg);
    assign hash_shifted = hash_index_word >> (6'd32 - 6'(bits_used));

    always_comb
    begin
        s0_idx = register_index;
        s0_val = (merge_value > RANK_MAX) ? RANK_MAX : merge_value;
        if (s0_op == OP_ADD)
        begin
            s0_idx = hash_shifted[RIDX_W-1:0];
            s0_val = rank_of(hash_rank_word);
        end
    end

    hll_ram #(
        .DATA_W (VAL_W),
        .DEPTH  (MAX_REGISTERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (s0_idx[ADDR_W-1:0]),
        .rdata (rd_data)
    );

    assign old_val = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : rd_data;
    assign grow    = s1_valid_reg && s1_hit_reg
                     && ((s1_op_reg == OP_ADD) || (s1_op_reg == OP_MERGE))
                     && (s1_val_reg > old_val);
    assign new_val = grow ? s1_val_reg : old_val;

    assign sweep_last = (sweep_addr_reg == ADDR_W'(reg_count - CNT_W'(1)));
    assign ram_we     = sweep_reg | grow;
    assign ram_waddr  = sweep_reg ? sweep_addr_reg : s1_addr_reg;
    assign ram_wdata  = sweep_reg ? '0 : s1_val_reg;

    always_comb
    begin
        value_next = '0;
        case (s1_op_reg) inside
            OP_ADD, OP_MERGE: value_next = s1_hit_reg ? new_val : '0;
            OP_READ:          value_next = s1_hit_reg ? old_val : '0;
            default:          value_next = '0;
        endcase
    end

    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        zc_next         = zc_reg;
        fwd_valid_next  = fwd_valid_reg | grow;
        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
            if (sweep_last)
            begin
                sweep_next = 1'b0;
            end
        end
        if (grow && (old_val == '0) && (zc_reg != '0))
        begin
            zc_next = zc_reg - CNT_W'(1);
        end
        if (s1_valid_reg && (s1_op_reg == OP_CLEAR))
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
            zc_next         = reg_count;
            fwd_valid_next  = 1'b0;
        end
        if (cfg_beat)
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
            zc_next         = count_of(cfg_data, MAX_CNT);
            fwd_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= INDEX_BITS_RESET;
            s1_valid_reg   <= 1'b0;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            zc_reg         <= count_of(INDEX_BITS_RESET, MAX_CNT);
            fwd_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_beat)
            begin
                index_bits_reg <= cfg_data;
            end
            s1_valid_reg   <= accept;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            zc_reg         <= zc_next;
            fwd_valid_reg  <= fwd_valid_next;
            done_reg       <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= s0_op;
            s1_addr_reg <= s0_idx[ADDR_W-1:0];
            s1_val_reg  <= s0_val;
            s1_hit_reg  <= ({1'b0, s0_idx} < reg_count);
        end
        if (grow)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= s1_val_reg;
        end
        value_reg <= value_next;
    end

    assign done           = done_reg;
    assign register_value = value_reg;
    assign zero_count     = zc_reg;

    a_done_follows_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(s1_valid_reg))
        else $error("result without a command beat");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> busy)
        else $error("command channel open during clearing pass");

    a_zc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        zc_reg <= reg_count)
        else $error("zero count above register count");

    a_value_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (value_reg <= RANK_MAX))
        else $error("register value above maximum rank");

    a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sweep_reg |-> !grow)
        else $error("register update during clearing pass");

endmodule
